[rtl/core/tspm_pkg.sv]
// ----------------------------------------------------------------------------
// tspm_pkg
// Shared types, constants and helpers of the token subsequence prefix matcher.
// ----------------------------------------------------------------------------
package tspm_pkg;

    localparam int TOKEN_MAX   = 8;
    localparam int MAX_TOKENS  = 32;
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 4;
    localparam int CNT_W       = 6;
    localparam int TOK_W       = $clog2(MAX_TOKENS);
    localparam int OFF_W       = $clog2(TOKEN_MAX);
    localparam int ENTRY_W     = TOKEN_MAX * CHAR_W;
    localparam int RECIP_W     = 12;
    localparam int RECIP_SHIFT = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;
    localparam int FIFO_DEPTH  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_COUNT  = 1'b1;

    // item kinds decided by the front end
    typedef enum logic [1:0] {
        K_LOAD   = 2'd0,   // pattern character, stored
        K_SKIP   = 2'd1,   // pattern character beyond the store, dropped
        K_STREAM = 2'd2,   // sequence character
        K_LAST   = 2'd3    // final sequence character, emits the count
    } t_kind;

    // one queued unit of work
    typedef struct packed {
        t_kind             kind;
        logic [TOK_W-1:0]  tok;
        logic [7:0]        pidx;
        logic [CHAR_W-1:0] sym;
    } t_work;

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // length register clamped to 1..TOKEN_MAX
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0) r = LEN_W'(1);
        else if (v > LEN_W'(TOKEN_MAX)) r = LEN_W'(TOKEN_MAX);
        else r = v;
        return r;
    endfunction

    // count register clamped to 1..MAX_TOKENS
    function automatic logic [CNT_W-1:0] eff_cnt(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) r = CNT_W'(1);
        else if (v > CNT_W'(MAX_TOKENS)) r = CNT_W'(MAX_TOKENS);
        else r = v;
        return r;
    endfunction

    // ceil(2^RECIP_SHIFT / len); exact quotient for 8-bit dividends
    function automatic logic [RECIP_W-1:0] recip(input logic [LEN_W-1:0] len);
        logic [RECIP_W-1:0] r;
        case (len)
            4'd1:    r = 12'd2048;
            4'd2:    r = 12'd1024;
            4'd3:    r = 12'd683;
            4'd4:    r = 12'd512;
            4'd5:    r = 12'd410;
            4'd6:    r = 12'd342;
            4'd7:    r = 12'd293;
            4'd8:    r = 12'd256;
            default: r = 12'd2048;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/tspm_front.sv]
// ----------------------------------------------------------------------------
// tspm_front
// Accepts items, works out the token index of pattern loads and sorts each
// item into a kind before it enters the work queue.
// ----------------------------------------------------------------------------
module tspm_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_func,
    input  logic [7:0]                   i_pidx,
    input  logic [tspm_pkg::CHAR_W-1:0]  i_sym,
    input  logic                         i_last,
    input  logic [tspm_pkg::LEN_W-1:0]   i_len,
    input  tspm_pkg::t_fifo_stat         i_stat,
    output logic                         o_push,
    output tspm_pkg::t_work              o_work
);

    localparam int PROD_W = 8 + tspm_pkg::RECIP_W;

    logic                  r_valid, n_valid;
    tspm_pkg::t_work       r_work, n_work;
    logic [PROD_W-1:0]     prod;
    logic [7:0]            quot;
    logic                  accept;

    assign o_ready = !r_valid || !i_stat.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_valid;
    assign o_work  = r_work;

    // pattern_index / len by reciprocal multiply
    assign prod = PROD_W'(i_pidx) * PROD_W'(tspm_pkg::recip(i_len));
    assign quot = prod[tspm_pkg::RECIP_SHIFT +: 8];

    // classify the incoming item
    always_comb begin
        n_work      = r_work;
        n_work.tok  = quot[tspm_pkg::TOK_W-1:0];
        n_work.pidx = i_pidx;
        n_work.sym  = i_sym;
        if (!i_func) begin
            n_work.kind = (quot < 8'(tspm_pkg::MAX_TOKENS)) ? tspm_pkg::K_LOAD
                                                            : tspm_pkg::K_SKIP;
        end else begin
            n_work.kind = i_last ? tspm_pkg::K_LAST : tspm_pkg::K_STREAM;
        end
    end

    // stage valid: loads on accept, drains into the queue
    always_comb begin
        n_valid = r_valid;
        if (accept) n_valid = 1'b1;
        else if (!i_stat.full) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_work <= n_work;
        end
    end

endmodule

[rtl/core/tspm_fifo.sv]
// ----------------------------------------------------------------------------
// tspm_fifo
// Short work queue that decouples the front end from the match engine.
// ----------------------------------------------------------------------------
module tspm_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  tspm_pkg::t_work       i_data,
    input  logic                  i_pop,
    output tspm_pkg::t_work       o_data,
    output tspm_pkg::t_fifo_stat  o_stat
);

    localparam int PTR_W = $clog2(tspm_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(tspm_pkg::FIFO_DEPTH + 1);

    tspm_pkg::t_work   r_mem [tspm_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_stat.full  = (r_cnt == CNT_W'(tspm_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) n_cnt = r_cnt + CNT_W'(1);
        else if (!do_push && do_pop) n_cnt = r_cnt - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) r_wr <= (r_wr == PTR_W'(tspm_pkg::FIFO_DEPTH - 1)) ? '0
                                                                            : r_wr + PTR_W'(1);
            if (do_pop)  r_rd <= (r_rd == PTR_W'(tspm_pkg::FIFO_DEPTH - 1)) ? '0
                                                                            : r_rd + PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/core/tspm_back.sv]
// ----------------------------------------------------------------------------
// tspm_back
// Match engine: writes pattern characters, slides the character window,
// compares it with the next unmatched token and emits the count.
// ----------------------------------------------------------------------------
module tspm_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tspm_pkg::t_work              i_work,
    input  tspm_pkg::t_fifo_stat         i_stat,
    output logic                         o_pop,
    input  logic [tspm_pkg::LEN_W-1:0]   i_len,
    input  logic [tspm_pkg::CNT_W-1:0]   i_cnt,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [tspm_pkg::CNT_W-1:0]   o_count,
    output logic                         o_full
);

    localparam int TM  = tspm_pkg::TOKEN_MAX;
    localparam int CW  = tspm_pkg::CHAR_W;
    localparam int EW  = tspm_pkg::ENTRY_W;
    localparam int LW  = tspm_pkg::LEN_W;
    localparam int CNW = tspm_pkg::CNT_W;
    localparam int FW  = tspm_pkg::OFF_W;
    localparam int PW  = tspm_pkg::TOK_W + LW;

    logic [EW-1:0]   r_store [tspm_pkg::MAX_TOKENS];
    logic [EW-1:0]   r_win, n_win;
    logic [FW-1:0]   r_fill, n_fill;
    logic [CNW-1:0]  r_tm, n_tm;
    logic            r_oval, n_oval;
    logic [CNW-1:0]  r_ocnt;
    logic            r_ofull;

    logic            out_free, is_stream, is_last, is_load;
    logic [PW-1:0]   base;
    logic [7:0]      off_full;
    logic [FW-1:0]   off;
    logic [EW-1:0]   tok_bytes;
    logic [TM-1:0]   hit_by_len;
    logic [LW-1:0]   len_m1;
    logic            enough, may_match, hit;

    assign out_free  = !r_oval || i_ready;
    assign is_last   = (i_work.kind == tspm_pkg::K_LAST);
    assign is_stream = (i_work.kind == tspm_pkg::K_STREAM) || is_last;
    assign is_load   = (i_work.kind == tspm_pkg::K_LOAD);
    assign o_pop     = !i_stat.empty && (!is_last || out_free);

    // byte offset inside the token: pidx - tok * len
    assign base     = PW'(i_work.tok) * PW'(i_len);
    assign off_full = i_work.pidx - 8'(base);
    assign off      = off_full[FW-1:0];

    // window after shifting in the current character
    assign n_win     = {r_win[EW-CW-1:0], i_work.sym};
    assign tok_bytes = r_store[r_tm[tspm_pkg::TOK_W-1:0]];

    // compare newest len characters with the token, one result per length
    always_comb begin
        for (int l = 1; l <= TM; l++) begin
            hit_by_len[l-1] = 1'b1;
            for (int o = 0; o < l; o++) begin
                if (n_win[CW*(l-1-o) +: CW] != tok_bytes[CW*o +: CW]) begin
                    hit_by_len[l-1] = 1'b0;
                end
            end
        end
    end

    assign len_m1    = i_len - LW'(1);
    assign hit       = hit_by_len[len_m1[FW-1:0]];
    assign enough    = ({1'b0, r_fill} + LW'(1)) >= i_len;
    assign may_match = enough && (r_tm < i_cnt) && (r_tm < CNW'(tspm_pkg::MAX_TOKENS));

    // match state update
    always_comb begin
        n_fill = r_fill;
        n_tm   = r_tm;
        if (o_pop && is_stream) begin
            if (may_match && hit) n_tm = r_tm + CNW'(1);
            if (r_fill != FW'(TM - 1)) n_fill = r_fill + FW'(1);
        end
    end

    // output register
    always_comb begin
        n_oval = r_oval;
        if (o_pop && is_last) n_oval = 1'b1;
        else if (i_ready) n_oval = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_fill <= '0;
            r_tm   <= '0;
            r_oval <= 1'b0;
        end else begin
            r_oval <= n_oval;
            if (o_pop && is_last) begin
                r_win  <= '0;
                r_fill <= '0;
                r_tm   <= '0;
            end else if (o_pop && is_stream) begin
                r_win  <= n_win;
                r_fill <= n_fill;
                r_tm   <= n_tm;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && is_last) begin
            r_ocnt  <= n_tm;
            r_ofull <= (n_tm >= i_cnt);
        end
    end

    // pattern store byte write
    always_ff @(posedge i_clk) begin
        if (o_pop && is_load) begin
            r_store[i_work.tok][CW*off +: CW] <= i_work.sym;
        end
    end

    assign o_valid = r_oval;
    assign o_count = r_ocnt;
    assign o_full  = r_ofull;

endmodule

[rtl/core/token_subsequence_prefix_match_top.sv]
// ----------------------------------------------------------------------------
// token_subsequence_prefix_match_top
// Counts how many leading pattern tokens occur in order in a character stream.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration channel (i_cfg_*): index 0 sets token_length, index 1 sets
//   token_count; always ready, write only while the block is idle.
//   Input stream (s_axis_*): tuser = func, 0 loads a pattern character at
//   pattern_index, 1 streams a sequence character; tlast marks the final
//   sequence character. tdata = {symbol, pattern_index}.
//   Output stream (m_axis_*): one item per final sequence character carrying
//   match_count and full_match; the match state then clears.
// Timing:
//   One item per cycle sustained while the output is not stalled. The last
//   character passes the front register, the work queue and the output register.
//   Each character costs one pass through the window compare in the match
//   engine; the store index feedback of that compare sets the per-cycle step.
// Reset and stalls:
//   Reset clears the window, counts and handshakes; the pattern store holds
//   garbage until loaded. A stalled output holds a final character at the
//   head of the queue; items behind it fill the two-entry queue and the
//   front register, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module token_subsequence_prefix_match_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tspm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tspm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // [7:0] pattern_index, [15:8] symbol
    input  logic                              s_axis_tuser,  // [0] func
    input  logic                              s_axis_tlast,  // last
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata   // [5:0] match_count, [6] full_match, [7] zero
);

    logic [tspm_pkg::LEN_W-1:0]  r_len;
    logic [tspm_pkg::CNT_W-1:0]  r_cnt;
    logic [tspm_pkg::LEN_W-1:0]  len_eff;
    logic [tspm_pkg::CNT_W-1:0]  cnt_eff;

    logic                        push, pop;
    tspm_pkg::t_work             front_work, queue_work;
    tspm_pkg::t_fifo_stat        stat;
    logic [tspm_pkg::CNT_W-1:0]  out_count;
    logic                        out_full;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= tspm_pkg::LEN_W'(1);
            r_cnt <= tspm_pkg::CNT_W'(tspm_pkg::MAX_TOKENS);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tspm_pkg::REG_TOKEN_LENGTH: r_len <= i_cfg_data[tspm_pkg::LEN_W-1:0];
                tspm_pkg::REG_TOKEN_COUNT:  r_cnt <= i_cfg_data[tspm_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign len_eff = tspm_pkg::eff_len(r_len);
    assign cnt_eff = tspm_pkg::eff_cnt(r_cnt);

    tspm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_func  (s_axis_tuser),
        .i_pidx  (s_axis_tdata[7:0]),
        .i_sym   (s_axis_tdata[15:8]),
        .i_last  (s_axis_tlast),
        .i_len   (len_eff),
        .i_stat  (stat),
        .o_push  (push),
        .o_work  (front_work)
    );

    tspm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_work),
        .i_pop   (pop),
        .o_data  (queue_work),
        .o_stat  (stat)
    );

    tspm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_work  (queue_work),
        .i_stat  (stat),
        .o_pop   (pop),
        .i_len   (len_eff),
        .i_cnt   (cnt_eff),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_count (out_count),
        .o_full  (out_full)
    );

    assign m_axis_tdata = {1'b0, out_full, out_count};

endmodule

[rtl/core/tspm_checker.sv]
// ----------------------------------------------------------------------------
// tspm_checker
// Port-level checks on the result stream of the prefix matcher.
// ----------------------------------------------------------------------------
module tspm_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready,
    input  logic [tspm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tspm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [7:0]                        m_axis_tdata
);

    // a held result keeps its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(m_axis_tvalid) && !$past(m_axis_tready)
        |-> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // count never passes the store size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[5:0] <= 6'(tspm_pkg::MAX_TOKENS))
        else $error("match count out of range");

    // a full match needs at least one token
    a_full_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[5:0] != 6'd0)
        else $error("full match with zero count");

    // no result is valid directly out of reset
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result right after reset");

endmodule

bind token_subsequence_prefix_match_top tspm_checker u_tspm_checker (.*);
